FILE: hdl/x86enc_pkg.sv
package x86enc_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 2;
	localparam int unsigned MAX_BYTES = 10;
	localparam int unsigned IDX_W = $clog2(MAX_BYTES);

	typedef enum logic [3:0] {
		OP_RET     = 4'd0,
		OP_NOP     = 4'd1,
		OP_PUSH    = 4'd2,
		OP_POP     = 4'd3,
		OP_MOV_RR  = 4'd4,
		OP_MOV_RI  = 4'd5,
		OP_XOR_RR  = 4'd6,
		OP_ADD_RR  = 4'd7,
		OP_ADD_RI  = 4'd8,
		OP_SUB_RR  = 4'd9,
		OP_SUB_RI  = 4'd10,
		OP_INC     = 4'd11,
		OP_DEC     = 4'd12,
		OP_IMUL_RR = 4'd13,
		OP_SYSCALL = 4'd14,
		OP_INT3    = 4'd15
	} op_t;

	localparam logic [7:0] B_REX_W     = 8'h48;
	localparam logic [7:0] B_REX_B     = 8'h41;
	localparam logic [7:0] B_RET       = 8'hC3;
	localparam logic [7:0] B_NOP       = 8'h90;
	localparam logic [7:0] B_INT3      = 8'hCC;
	localparam logic [7:0] B_PUSH      = 8'h50;
	localparam logic [7:0] B_POP       = 8'h58;
	localparam logic [7:0] B_MOV_RR    = 8'h89;
	localparam logic [7:0] B_XOR_RR    = 8'h31;
	localparam logic [7:0] B_ADD_RR    = 8'h01;
	localparam logic [7:0] B_SUB_RR    = 8'h29;
	localparam logic [7:0] B_MOV_RI    = 8'hB8;
	localparam logic [7:0] B_GRP_IMM8  = 8'h83;
	localparam logic [7:0] B_GRP_IMM32 = 8'h81;
	localparam logic [7:0] B_GRP_FF    = 8'hFF;
	localparam logic [7:0] B_ESC       = 8'h0F;
	localparam logic [7:0] B_IMUL      = 8'hAF;
	localparam logic [7:0] B_SYSCALL   = 8'h05;
	localparam logic [7:0] M_RR        = 8'hC0;
	localparam logic [7:0] M_ADD       = 8'hC0;
	localparam logic [7:0] M_SUB       = 8'hE8;
	localparam logic [7:0] M_INC       = 8'hC0;
	localparam logic [7:0] M_DEC       = 8'hC8;

	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [IDX_W-1:0]          last_idx;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic [7:0] rex_w(input logic [3:0] reg_f, input logic [3:0] rm_f);
		rex_w = B_REX_W | {5'b0, reg_f[3], 1'b0, rm_f[3]};
	endfunction

	function automatic logic [7:0] modrm(input logic [7:0] base, input logic [3:0] reg_f,
			input logic [3:0] rm_f);
		modrm = base | {2'b0, reg_f[2:0], rm_f[2:0]};
	endfunction

endpackage

FILE: hdl/x86_64_instruction_encoder.sv
// channel   | ports                                                 | transfer
// ----------+-------------------------------------------------------+---------------------
// request   | start, busy, operation, dest_register,                | start && !busy
//           | source_register, immediate                            |
// result    | strobe, code_byte, last                               | strobe, one cycle
//
// An instruction of n bytes (1 to 10) holds the byte serializer until its last byte is
// out; it emits one byte per cycle while the queue is not empty (the sustained rate).
// A request is stored in the queue, and its bytes are then registered onto the ports.
// Requests are taken every cycle while the instruction queue has room; busy means full.
// Reset clears the queue, the byte index and strobe; the receiver cannot stall.
module x86_64_instruction_encoder #(
	parameter int unsigned QUEUE_DEPTH = x86enc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [3:0]         operation,
	input  logic [3:0]         dest_register,
	input  logic [3:0]         source_register,
	input  logic signed [63:0] immediate,
	output logic [7:0]         code_byte,
	output logic               last,
	output logic               strobe
);
	import x86enc_pkg::*;

	entry_t    enc_entry;
	entry_t    head;
	q_status_t q_status;
	logic      push;
	logic      pop;

	assign busy = q_status.full;
	assign push = start && !q_status.full;

	x86enc_front u_front (
		.operation       (op_t'(operation)),
		.dest_register   (dest_register),
		.source_register (source_register),
		.immediate       (immediate),
		.entry           (enc_entry)
	);

	x86enc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (enc_entry),
		.pop        (pop),
		.head       (head),
		.status     (q_status)
	);

	x86enc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.status    (q_status),
		.pop       (pop),
		.code_byte (code_byte),
		.last      (last),
		.strobe    (strobe)
	);

endmodule

FILE: hdl/x86enc_front.sv
module x86enc_front (
	input  x86enc_pkg::op_t    operation,
	input  logic [3:0]         dest_register,
	input  logic [3:0]         source_register,
	input  logic signed [63:0] immediate,
	output x86enc_pkg::entry_t entry
);
	import x86enc_pkg::*;

	logic imm_small;

	// fits imm8 when bits 63..7 are all equal
	assign imm_small = (&immediate[63:7]) | ~(|immediate[63:7]);

	always_comb begin
		entry = '0;
		unique case (operation)
			OP_RET: entry.bytes[0] = B_RET;
			OP_NOP: entry.bytes[0] = B_NOP;
			OP_PUSH, OP_POP: begin
				if (dest_register[3]) begin
					entry.bytes[0] = B_REX_B;
					entry.bytes[1] = ((operation == OP_PUSH) ? B_PUSH : B_POP)
						| {5'b0, dest_register[2:0]};
					entry.last_idx = IDX_W'(1);
				end else begin
					entry.bytes[0] = ((operation == OP_PUSH) ? B_PUSH : B_POP)
						| {5'b0, dest_register[2:0]};
				end
			end
			OP_MOV_RR, OP_XOR_RR, OP_ADD_RR, OP_SUB_RR: begin
				entry.bytes[0] = rex_w(source_register, dest_register);
				unique case (operation)
					OP_MOV_RR: entry.bytes[1] = B_MOV_RR;
					OP_XOR_RR: entry.bytes[1] = B_XOR_RR;
					OP_ADD_RR: entry.bytes[1] = B_ADD_RR;
					default:   entry.bytes[1] = B_SUB_RR;
				endcase
				entry.bytes[2] = modrm(M_RR, source_register, dest_register);
				entry.last_idx = IDX_W'(2);
			end
			OP_MOV_RI: begin
				entry.bytes[0] = rex_w(4'd0, dest_register);
				entry.bytes[1] = B_MOV_RI | {5'b0, dest_register[2:0]};
				for (int i = 0; i < 8; i++)
					entry.bytes[2+i] = immediate[8*i +: 8];
				entry.last_idx = IDX_W'(9);
			end
			OP_ADD_RI, OP_SUB_RI: begin
				entry.bytes[0] = rex_w(4'd0, dest_register);
				entry.bytes[2] = modrm((operation == OP_ADD_RI) ? M_ADD : M_SUB,
					4'd0, dest_register);
				if (imm_small) begin
					entry.bytes[1] = B_GRP_IMM8;
					entry.bytes[3] = immediate[7:0];
					entry.last_idx = IDX_W'(3);
				end else begin
					entry.bytes[1] = B_GRP_IMM32;
					for (int i = 0; i < 4; i++)
						entry.bytes[3+i] = immediate[8*i +: 8];
					entry.last_idx = IDX_W'(6);
				end
			end
			OP_INC, OP_DEC: begin
				entry.bytes[0] = rex_w(4'd0, dest_register);
				entry.bytes[1] = B_GRP_FF;
				entry.bytes[2] = modrm((operation == OP_INC) ? M_INC : M_DEC,
					4'd0, dest_register);
				entry.last_idx = IDX_W'(2);
			end
			OP_IMUL_RR: begin
				entry.bytes[0] = rex_w(dest_register, source_register);
				entry.bytes[1] = B_ESC;
				entry.bytes[2] = B_IMUL;
				entry.bytes[3] = modrm(M_RR, dest_register, source_register);
				entry.last_idx = IDX_W'(3);
			end
			OP_SYSCALL: begin
				entry.bytes[0] = B_ESC;
				entry.bytes[1] = B_SYSCALL;
				entry.last_idx = IDX_W'(1);
			end
			OP_INT3: entry.bytes[0] = B_INT3;
			default: entry.bytes[0] = B_INT3;
		endcase
	end

endmodule

FILE: hdl/x86enc_queue.sv
module x86enc_queue #(
	parameter int unsigned DEPTH = x86enc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  x86enc_pkg::entry_t    push_entry,
	input  logic                  pop,
	output x86enc_pkg::entry_t    head,
	output x86enc_pkg::q_status_t status
);
	import x86enc_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	entry_t             store_q [DEPTH];
	logic [PTR_W-1:0]   wr_q;
	logic [PTR_W-1:0]   rd_q;
	logic [CNT_W-1:0]   cnt_q;

	function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
		wrap_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign status.full  = (cnt_q == CNT_W'(DEPTH));
	assign status.empty = (cnt_q == '0);
	assign head         = store_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			store_q[wr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wrap_inc(wr_q);
			if (pop)
				rd_q <= wrap_inc(rd_q);
			if (push && !pop)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH)) else $error("queue count overflow");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !status.empty) else $error("pop from empty queue");
	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> !status.empty) else $error("push lost");
`endif

endmodule

FILE: hdl/x86enc_back.sv
module x86enc_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  x86enc_pkg::entry_t    head,
	input  x86enc_pkg::q_status_t status,
	output logic                  pop,
	output logic [7:0]            code_byte,
	output logic                  last,
	output logic                  strobe
);
	import x86enc_pkg::*;

	logic [IDX_W-1:0] idx_q;
	logic [7:0]       byte_q;
	logic             last_q;
	logic             strobe_q;
	logic             at_end;

	assign at_end    = (idx_q == head.last_idx);
	assign pop       = !status.empty && at_end;
	assign code_byte = byte_q;
	assign last      = last_q;
	assign strobe    = strobe_q;

	always_ff @(posedge clk) begin
		if (!status.empty) begin
			byte_q <= head.bytes[idx_q];
			last_q <= at_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= !status.empty;
			if (!status.empty)
				idx_q <= at_end ? '0 : idx_q + IDX_W'(1);
		end
	end

`ifndef SYNTHESIS
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!status.empty |-> idx_q <= head.last_idx) else $error("byte index past end");
	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		status.empty |-> idx_q == '0) else $error("index not rewound");
	a_strobe_follows: assert property (@(posedge clk) disable iff (!arst_n)
		!status.empty |=> strobe_q) else $error("byte not strobed");
`endif

endmodule

FILE: tb/x86enc_byte_checker.sv
module x86enc_byte_checker
	import x86enc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [3:0]         operation,
	input  logic [3:0]         dest_register,
	input  logic [3:0]         source_register,
	input  logic signed [63:0] immediate,
	input  logic               strobe,
	input  logic [7:0]         code_byte,
	input  logic               last,
	output int                 mismatches,
	output int                 bytes_due
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] code;
		logic       fin;
	} code_byte_t;

	code_byte_t due_q[$];

	function automatic logic [7:0] rex_byte(input logic r_ext, input logic b_ext);
		return B_REX_W | {5'b0, r_ext, 1'b0, b_ext};
	endfunction

	function automatic void predict_encoding(input op_t op, input logic [3:0] rd,
			input logic [3:0] rs, input logic signed [63:0] imm);
		logic [7:0] seq[$];
		logic [7:0] opc;
		logic       fits8;
		code_byte_t item;
		fits8 = (imm >= -64'sd128) && (imm <= 64'sd127);
		opc = 8'h00;
		case (op)
			OP_RET: seq = {seq, B_RET};
			OP_NOP: seq = {seq, B_NOP};
			OP_PUSH, OP_POP: begin
				if (rd[3])
					seq = {seq, B_REX_B};
				seq = {seq, ((op == OP_PUSH) ? B_PUSH : B_POP) | {5'b0, rd[2:0]}};
			end
			OP_MOV_RR, OP_XOR_RR, OP_ADD_RR, OP_SUB_RR: begin
				case (op)
					OP_MOV_RR: opc = B_MOV_RR;
					OP_XOR_RR: opc = B_XOR_RR;
					OP_ADD_RR: opc = B_ADD_RR;
					default:   opc = B_SUB_RR;
				endcase
				seq = {seq, rex_byte(rs[3], rd[3])};
				seq = {seq, opc};
				seq = {seq, M_RR | {2'b0, rs[2:0], rd[2:0]}};
			end
			OP_MOV_RI: begin
				seq = {seq, rex_byte(1'b0, rd[3])};
				seq = {seq, B_MOV_RI | {5'b0, rd[2:0]}};
				for (int i = 0; i < 8; i++)
					seq = {seq, imm[8*i +: 8]};
			end
			OP_ADD_RI, OP_SUB_RI: begin
				seq = {seq, rex_byte(1'b0, rd[3])};
				seq = {seq, fits8 ? B_GRP_IMM8 : B_GRP_IMM32};
				seq = {seq, ((op == OP_ADD_RI) ? M_ADD : M_SUB) | {5'b0, rd[2:0]}};
				for (int i = 0; i < (fits8 ? 1 : 4); i++)
					seq = {seq, imm[8*i +: 8]};
			end
			OP_INC, OP_DEC: begin
				seq = {seq, rex_byte(1'b0, rd[3])};
				seq = {seq, B_GRP_FF};
				seq = {seq, ((op == OP_INC) ? M_INC : M_DEC) | {5'b0, rd[2:0]}};
			end
			OP_IMUL_RR: begin
				seq = {seq, rex_byte(rd[3], rs[3])};
				seq = {seq, B_ESC};
				seq = {seq, B_IMUL};
				seq = {seq, M_RR | {2'b0, rd[2:0], rs[2:0]}};
			end
			OP_SYSCALL: begin
				seq = {seq, B_ESC};
				seq = {seq, B_SYSCALL};
			end
			default: seq = {seq, B_INT3};
		endcase
		foreach (seq[i]) begin
			item.code = seq[i];
			item.fin  = (i == seq.size() - 1);
			due_q = {due_q, item};
		end
	endfunction

	initial begin
		mismatches = 0;
		bytes_due  = 0;
	end

	always @(posedge clk) begin
		code_byte_t want;
		if (arst_n) begin
			if (strobe) begin
				if (due_q.size() == 0) begin
					$error("unexpected transfer: code_byte=%h last=%b", code_byte, last);
					mismatches++;
				end else begin
					want = due_q.pop_front();
					if (code_byte !== want.code) begin
						$error("code_byte: expected %h, actual %h", want.code, code_byte);
						mismatches++;
					end
					if (last !== want.fin) begin
						$error("last: expected %b, actual %b", want.fin, last);
						mismatches++;
					end
				end
			end
			if (start && !busy)
				predict_encoding(op_t'(operation), dest_register, source_register, immediate);
			bytes_due <= due_q.size();
		end
	end

endmodule

FILE: tb/tb_x86_64_instruction_encoder.sv
module tb_x86_64_instruction_encoder;
	import x86enc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 354;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 16;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [3:0]         operation;
	logic [3:0]         dest_register;
	logic [3:0]         source_register;
	logic signed [63:0] immediate;
	logic [7:0]         code_byte;
	logic               last;
	logic               strobe;
	int                 mismatches;
	int                 bytes_due;
	int                 cycles = 0;

	always #1 clk = ~clk;

	x86_64_instruction_encoder dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.operation       (operation),
		.dest_register   (dest_register),
		.source_register (source_register),
		.immediate       (immediate),
		.code_byte       (code_byte),
		.last            (last),
		.strobe          (strobe)
	);

	x86enc_byte_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.operation       (operation),
		.dest_register   (dest_register),
		.source_register (source_register),
		.immediate       (immediate),
		.strobe          (strobe),
		.code_byte       (code_byte),
		.last            (last),
		.mismatches      (mismatches),
		.bytes_due       (bytes_due)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic send_instr(input op_t op, input logic [3:0] rd, input logic [3:0] rs,
			input logic signed [63:0] imm, input int gap);
		start           <= 1'b1;
		operation       <= op;
		dest_register   <= rd;
		source_register <= rs;
		immediate       <= imm;
		do
			@(posedge clk);
		while (busy);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic signed [63:0] pick_imm();
		int v;
		case ($urandom_range(0, 5))
			0: begin
				v = $urandom_range(0, 255);
				return 64'(v - 128);
			end
			1: begin
				case ($urandom_range(0, 7))
					0: return 64'sd127;
					1: return 64'sd128;
					2: return -64'sd128;
					3: return -64'sd129;
					4: return 64'sh7FFF_FFFF;
					5: return -64'sh8000_0000;
					6: return 64'sh8000_0000_0000_0000;
					default: return 64'sh7FFF_FFFF_FFFF_FFFF;
				endcase
			end
			2: begin
				v = $urandom;
				return 64'(v);
			end
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic int pick_gap(input int idx);
		int r;
		if ((idx / 40) % 3 == 1)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	initial begin
		arst_n          <= 1'b0;
		start           <= 1'b0;
		operation       <= OP_NOP;
		dest_register   <= 4'd0;
		source_register <= 4'd0;
		immediate       <= 64'sd0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every kind, register extremes, imm8/imm32 boundaries
		send_instr(OP_RET,     4'd0,  4'($urandom), pick_imm(), 0);
		send_instr(OP_NOP,     4'd15, 4'($urandom), pick_imm(), 0);
		send_instr(OP_PUSH,    4'd0,  4'($urandom), pick_imm(), 0);
		send_instr(OP_PUSH,    4'd15, 4'($urandom), pick_imm(), 1);
		send_instr(OP_POP,     4'd8,  4'($urandom), pick_imm(), 0);
		send_instr(OP_POP,     4'd7,  4'($urandom), pick_imm(), 0);
		send_instr(OP_MOV_RR,  4'd15, 4'd0,     pick_imm(), 0);
		send_instr(OP_MOV_RR,  4'd0,  4'd15,    pick_imm(), 2);
		send_instr(OP_MOV_RI,  4'd9,  4'($urandom), 64'sh8000_0000_0000_0000, 0);
		send_instr(OP_MOV_RI,  4'd0,  4'($urandom), 64'sh7FFF_FFFF_FFFF_FFFF, 0);
		send_instr(OP_XOR_RR,  4'd15, 4'd15,    pick_imm(), 0);
		send_instr(OP_ADD_RR,  4'd8,  4'd3,     pick_imm(), 0);
		send_instr(OP_ADD_RI,  4'd1,  4'($urandom), 64'sd127, 0);
		send_instr(OP_ADD_RI,  4'd12, 4'($urandom), 64'sd128, 0);
		send_instr(OP_ADD_RI,  4'd5,  4'($urandom), -64'sd128, 0);
		send_instr(OP_ADD_RI,  4'd3,  4'($urandom), 64'sh8000_0000_0000_0000, 3);
		send_instr(OP_SUB_RI,  4'd13, 4'($urandom), -64'sd129, 0);
		send_instr(OP_SUB_RI,  4'd2,  4'($urandom), -64'sd1, 0);
		send_instr(OP_SUB_RI,  4'd14, 4'($urandom), 64'sh7FFF_FFFF_FFFF_FFFF, 0);
		send_instr(OP_SUB_RR,  4'd11, 4'd6,     pick_imm(), 0);
		send_instr(OP_INC,     4'd15, 4'($urandom), pick_imm(), 0);
		send_instr(OP_DEC,     4'd0,  4'($urandom), pick_imm(), 0);
		send_instr(OP_IMUL_RR, 4'd15, 4'd2,     pick_imm(), 0);
		send_instr(OP_IMUL_RR, 4'd3,  4'd12,    pick_imm(), 0);
		send_instr(OP_SYSCALL, 4'($urandom), 4'($urandom), pick_imm(), 0);
		send_instr(OP_INT3,    4'($urandom), 4'($urandom), pick_imm(), 5);

		for (int i = 0; i < RANDOM_ITEMS; i++)
			send_instr(op_t'($urandom_range(0, 15)), 4'($urandom), 4'($urandom),
					pick_imm(), pick_gap(i));
		start <= 1'b0;

		@(posedge clk);
		while (bytes_due != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (bytes_due != 0)
			$error("%0d expected bytes never arrived", bytes_due);
		if (mismatches == 0 && bytes_due == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: sim.f
hdl/x86enc_pkg.sv
hdl/x86enc_front.sv
hdl/x86enc_queue.sv
hdl/x86enc_back.sv
hdl/x86_64_instruction_encoder.sv
tb/x86enc_byte_checker.sv
tb/tb_x86_64_instruction_encoder.sv
